[rtl/per_cpu_page_allocator_steal_top_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the per-CPU page allocator
// Shared property wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef PER_CPU_PAGE_ALLOCATOR_STEAL_TOP_DEFINES_SVH
`define PER_CPU_PAGE_ALLOCATOR_STEAL_TOP_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define PCPA_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define PCPA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/pcpa_pkg.sv]
// ----------------------------------------------------------------------------
// pcpa_pkg
// Types and constants shared by the per-CPU page allocator.
// ----------------------------------------------------------------------------
package pcpa_pkg;

  localparam int unsigned RegW   = 11;
  localparam int unsigned CpuW   = 3;
  localparam int unsigned PageW  = 10;
  localparam int unsigned CountW = 11;
  localparam logic [CountW-1:0] CountMax = 11'd2047;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNoMem   = 2'd1;
  localparam logic [1:0] StBadPage = 2'd2;

  localparam logic FuncFree  = 1'b0;
  localparam logic FuncAlloc = 1'b1;

  localparam logic RegLowPage   = 1'b0;
  localparam logic RegPageLimit = 1'b1;

  // one result transaction
  typedef struct packed {
    logic [1:0]        status;
    logic [PageW-1:0]  granted_page;
    logic [CountW-1:0] moved_pages;
  } result_t;

endpackage

[rtl/per_cpu_page_allocator_steal_top.sv]
// Free writes the link and reports; allocate pops in a read and a write-back
//   state, after the scan and steal loop if empty; one transaction at a time.
// The next-link memory has one read port, so each stolen page costs a read
//   and a write-back state; the victim search scans one CPU count per cycle.
// Reset clears counts, registers and control; link memory and heads start
//   undefined and need no clearing pass.
// ----------------------------------------------------------------------------
// per_cpu_page_allocator_steal_top
// Per-CPU LIFO page allocator with stealing from the fullest other CPU.
// ----------------------------------------------------------------------------
module per_cpu_page_allocator_steal_top #(
  parameter int unsigned NUM_PAGES = 1024,
  parameter int unsigned NUM_CPUS  = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [pcpa_pkg::RegW-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          func_i,
  input  logic [pcpa_pkg::CpuW-1:0]     cpu_id_i,
  input  logic [pcpa_pkg::PageW-1:0]    page_number_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [pcpa_pkg::PageW-1:0]    granted_page_o,
  output logic [pcpa_pkg::CountW-1:0]   moved_pages_o
);

  localparam int unsigned AddrW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int unsigned CIdxW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_STEAL_RD, S_STEAL_WR, S_POP_RD, S_POP_WR, S_OUT
  } state_e;

  state_e state_q;
  logic [pcpa_pkg::RegW-1:0] low_q, limit_q;
  logic [pcpa_pkg::CountW-1:0] count_q [NUM_CPUS];
  logic [pcpa_pkg::PageW-1:0]  head_q  [NUM_CPUS];
  logic [CIdxW-1:0] cpu_q, victim_q, scan_q;
  logic [pcpa_pkg::CountW-1:0] best_q, moved_q;
  logic [pcpa_pkg::PageW-1:0] page_q;
  pcpa_pkg::result_t res_q;

  logic we;
  logic [AddrW-1:0] waddr, raddr;
  logic [pcpa_pkg::PageW-1:0] wdata, rdata;

  pcpa_link_mem #(.Depth(NUM_PAGES), .AddrW(AddrW)) u_link (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  logic cpu_ok, page_ok;
  logic [CIdxW-1:0] in_cpu;
  logic [pcpa_pkg::RegW-1:0] page_ext;

  assign in_cpu   = CIdxW'(cpu_id_i);
  assign cpu_ok   = ({29'd0, cpu_id_i} < 32'(NUM_CPUS));
  assign page_ext = {1'b0, page_number_i};
  assign page_ok  = (page_ext >= low_q) && (page_ext < limit_q) &&
                    ({22'd0, page_number_i} < 32'(NUM_PAGES));

  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_o;
  assign cfg_ready_o = 1'b1;

  // memory port control
  always_comb begin
    we    = 1'b0;
    waddr = AddrW'(page_number_i);
    wdata = head_q[in_cpu];
    raddr = AddrW'(head_q[cpu_q]);
    case (state_q)
      S_IDLE: begin
        we = in_valid_i && in_ready_o && (func_i == pcpa_pkg::FuncFree) &&
             cpu_ok && page_ok && (count_q[in_cpu] < pcpa_pkg::CountMax);
      end
      S_STEAL_RD: raddr = AddrW'(head_q[victim_q]);
      S_STEAL_WR: begin
        we    = 1'b1;
        waddr = AddrW'(head_q[victim_q]);
        wdata = head_q[cpu_q];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      low_q       <= '0;
      limit_q     <= 11'd1024;
      out_valid_o <= 1'b0;
      for (int i = 0; i < NUM_CPUS; i++) count_q[i] <= '0;
      cpu_q <= '0; victim_q <= '0; scan_q <= '0;
      best_q <= '0; moved_q <= '0;
      res_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == pcpa_pkg::RegLowPage) low_q <= cfg_data_i;
        else limit_q <= cfg_data_i;
      end
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            cpu_q   <= in_cpu;
            moved_q <= '0;
            if (func_i == pcpa_pkg::FuncFree) begin
              if (we) begin
                head_q[in_cpu]  <= page_number_i;
                count_q[in_cpu] <= count_q[in_cpu] + 1'b1;
              end
              res_q <= '{status: (we ? pcpa_pkg::StOk : pcpa_pkg::StBadPage),
                         default: '0};
              state_q <= S_OUT;
            end else if (!cpu_ok) begin
              res_q   <= '{status: pcpa_pkg::StNoMem, default: '0};
              state_q <= S_OUT;
            end else if (count_q[in_cpu] != '0) begin
              res_q   <= '0;
              state_q <= S_POP_RD;
            end else begin
              res_q  <= '0;
              scan_q <= '0; best_q <= '0; victim_q <= in_cpu;
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_q != cpu_q && count_q[scan_q] > best_q) begin
            best_q   <= count_q[scan_q];
            victim_q <= scan_q;
          end
          if (32'(scan_q) == NUM_CPUS - 1) state_q <= S_STEAL_RD;
          else scan_q <= scan_q + 1'b1;
        end
        S_STEAL_RD: begin
          if (victim_q != cpu_q && count_q[cpu_q] < count_q[victim_q])
            state_q <= S_STEAL_WR;
          else if (count_q[cpu_q] != '0)
            state_q <= S_POP_RD;
          else begin
            res_q.status <= pcpa_pkg::StNoMem;
            state_q <= S_OUT;
          end
        end
        S_STEAL_WR: begin
          head_q[victim_q]  <= rdata;
          head_q[cpu_q]     <= head_q[victim_q];
          count_q[victim_q] <= count_q[victim_q] - 1'b1;
          count_q[cpu_q]    <= count_q[cpu_q] + 1'b1;
          moved_q           <= moved_q + 1'b1;
          state_q           <= S_STEAL_RD;
        end
        S_POP_RD: begin
          page_q  <= head_q[cpu_q];
          state_q <= S_POP_WR;
        end
        S_POP_WR: begin
          head_q[cpu_q]  <= rdata;
          count_q[cpu_q] <= count_q[cpu_q] - 1'b1;
          res_q.granted_page <= page_q;
          state_q <= S_OUT;
        end
        S_OUT: begin
          res_q.moved_pages <= moved_q;
          out_valid_o <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign status_o       = res_q.status;
  assign granted_page_o = res_q.granted_page;
  assign moved_pages_o  = res_q.moved_pages;

endmodule

[rtl/pcpa_link_mem.sv]
// ----------------------------------------------------------------------------
// pcpa_link_mem
// Next-link store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pcpa_link_mem #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AddrW-1:0]         waddr_i,
  input  logic [pcpa_pkg::PageW-1:0] wdata_i,
  input  logic [AddrW-1:0]         raddr_i,
  output logic [pcpa_pkg::PageW-1:0] rdata_o
);

  logic [pcpa_pkg::PageW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[rtl/pcpa_checker.sv]
// ----------------------------------------------------------------------------
// pcpa_checker
// Port-level checks on the page allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "per_cpu_page_allocator_steal_top_defines.svh"

module pcpa_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] status_o,
  input logic [9:0] granted_page_o,
  input logic [10:0] moved_pages_o
);

  `PCPA_ASSERT_IMPL(a_status_range, clk_i, rst_ni, out_valid_o, status_o != 2'd3)
  `PCPA_ASSERT_IMPL(a_err_no_page, clk_i, rst_ni,
                    out_valid_o && status_o != pcpa_pkg::StOk, granted_page_o == 10'd0)
  `PCPA_ASSERT_IMPL(a_one_at_a_time, clk_i, rst_ni, out_valid_o, !in_ready_o)
  `PCPA_ASSERT_NEXT(a_out_holds, clk_i, rst_ni, out_valid_o && !out_ready_i,
                    out_valid_o && $stable(moved_pages_o))

endmodule

bind per_cpu_page_allocator_steal_top pcpa_checker u_pcpa_checker (.*);
